@@ design/ecpad_pkg.sv @@
// Package for the affine point add/double block: field width, payload
// structs, register indexes and sequencer states. No dependencies.
package ecpad_pkg;

  localparam int FIELD_BITS = 64;
  localparam int CNT_BITS   = $clog2(FIELD_BITS + 1);
  localparam int CFG_IDX_BITS = 1;

  typedef logic [FIELD_BITS-1:0] fe_t;

  typedef struct packed {
    logic [63:0] px;
    logic [63:0] py;
    logic [63:0] qx;
    logic [63:0] qy;
  } in_item_t;

  typedef struct packed {
    logic [63:0] rx;
    logic [63:0] ry;
    logic        at_infinity;
    logic        was_doubling;
  } out_item_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CURVE_A = 1'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED,      // reduce operands one at a time (shift-subtract)
    ST_PREP,     // equality test, numerator/denominator setup
    ST_SQ,       // px^2 for doubling
    ST_NUM,      // 3*sq + a
    ST_INV_DIV,  // Euclid quotient, bit-serial long division
    ST_INV_MUL,  // quo*t1 mod m
    ST_INV_UPD,  // update remainder/cofactor pairs
    ST_LAM,      // num * inv
    ST_LSQ,      // lam^2
    ST_X3,
    ST_Y3M,      // lam*(xp-x3)
    ST_Y3,
    ST_DONE
  } state_t;

endpackage

@@ design/ec_affine_point_add_double.sv @@
// Top level of the affine point add/double block: register file, sequencer
// and one shared modular datapath. Depends on ecpad_pkg.
//
//  channel | ports                          | payload
//  input   | in_valid  / in_ready           | in_data  (px, py, qx, qy)
//  result  | out_valid / out_ready          | out_data (rx, ry, flags)
//  config  | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// One item at a time. Operand reduction handles px, py, qx, qy and a in turn;
// each modular multiply runs one double-and-add step a cycle. Each inversion
// round is a Euclid division, a multiply and an update. A modulus below two
// skips straight to an at-infinity result, and a zero denominator ends the
// inversion with an at-infinity result.
// The result sits in an output register; a new item is taken only once
// it has been transferred. Reset (sync, active low) restores p=3, a=0.
module ec_affine_point_add_double (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ecpad_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ecpad_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ecpad_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [63:0]           cfg_data
);

  localparam int FB = ecpad_pkg::FIELD_BITS;

  ecpad_pkg::state_t state_r, state_nxt;

  ecpad_pkg::fe_t m_r, a_r;
  ecpad_pkg::fe_t xp_r, yp_r, xq_r, yq_r, ca_r;
  ecpad_pkg::fe_t num_r, sq_r, lam_r, x3_r;
  // Euclid state
  ecpad_pkg::fe_t r0_r, r1_r, t0_r, t1_r, quo_r, rem_r;
  // shared unit operands / accumulator
  ecpad_pkg::fe_t acc_r, opx_r, opy_r;
  logic [ecpad_pkg::CNT_BITS-1:0] cnt_r;
  logic [2:0] sel_r;      // operand being reduced
  logic dbl_r, deg_r, inf_r, ovalid_r;
  ecpad_pkg::out_item_t out_r;

  // modular add/sub helpers (inputs below m)
  function automatic ecpad_pkg::fe_t fadd(ecpad_pkg::fe_t x, ecpad_pkg::fe_t y,
                                          ecpad_pkg::fe_t m);
    logic [FB:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[FB-1:0];
  endfunction

  function automatic ecpad_pkg::fe_t fsub(ecpad_pkg::fe_t x, ecpad_pkg::fe_t y,
                                          ecpad_pkg::fe_t m);
    return (x >= y) ? (x - y) : (x + (m - y));
  endfunction

  // double-and-add step, scanning opy from the top
  ecpad_pkg::fe_t mul_step;
  always_comb begin
    mul_step = fadd(acc_r, acc_r, m_r);
    if (opy_r[FB-1]) mul_step = fadd(mul_step, opx_r, m_r);
  end

  // restoring division step: rem shifted, next dividend bit from opy
  logic [FB:0] div_trial;
  logic        div_ge;
  always_comb begin
    div_trial = {rem_r, opy_r[FB-1]};
    div_ge    = div_trial >= {1'b0, opx_r};
  end

  wire done_cnt = (cnt_r == ecpad_pkg::CNT_BITS'(FB - 1));
  wire div_last = (cnt_r == ecpad_pkg::CNT_BITS'(FB - 1));

  assign in_ready  = (state_r == ecpad_pkg::ST_IDLE) && !ovalid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ecpad_pkg::ST_IDLE:    if (in_valid && in_ready) state_nxt = ecpad_pkg::ST_RED;
      ecpad_pkg::ST_RED:     if (deg_r) state_nxt = ecpad_pkg::ST_DONE;
                             else if (div_last && sel_r == 3'd4)
                               state_nxt = ecpad_pkg::ST_PREP;
      // doubling judged on the reduced coordinates
      ecpad_pkg::ST_PREP:    state_nxt = (xp_r == xq_r && yp_r == yq_r) ?
                                         ecpad_pkg::ST_SQ : ecpad_pkg::ST_INV_DIV;
      ecpad_pkg::ST_SQ:      if (done_cnt) state_nxt = ecpad_pkg::ST_NUM;
      ecpad_pkg::ST_NUM:     state_nxt = ecpad_pkg::ST_INV_DIV;
      ecpad_pkg::ST_INV_DIV: if (r1_r == '0) state_nxt = ecpad_pkg::ST_LAM;
                             else if (div_last) state_nxt = ecpad_pkg::ST_INV_MUL;
      ecpad_pkg::ST_INV_MUL: if (done_cnt) state_nxt = ecpad_pkg::ST_INV_UPD;
      ecpad_pkg::ST_INV_UPD: state_nxt = ecpad_pkg::ST_INV_DIV;
      ecpad_pkg::ST_LAM:     if (r0_r != ecpad_pkg::fe_t'(1)) state_nxt = ecpad_pkg::ST_DONE;
                             else if (done_cnt) state_nxt = ecpad_pkg::ST_LSQ;
      ecpad_pkg::ST_LSQ:     if (done_cnt) state_nxt = ecpad_pkg::ST_X3;
      ecpad_pkg::ST_X3:      state_nxt = ecpad_pkg::ST_Y3M;
      ecpad_pkg::ST_Y3M:     if (done_cnt) state_nxt = ecpad_pkg::ST_Y3;
      ecpad_pkg::ST_Y3:      state_nxt = ecpad_pkg::ST_DONE;
      ecpad_pkg::ST_DONE:    state_nxt = ecpad_pkg::ST_IDLE;
      default:               state_nxt = ecpad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ecpad_pkg::ST_IDLE;
      m_r      <= ecpad_pkg::fe_t'(3);
      a_r      <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ecpad_pkg::REG_MODULUS) m_r <= cfg_data[FB-1:0];
        if (cfg_index == ecpad_pkg::REG_CURVE_A) a_r <= cfg_data[FB-1:0];
      end
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      if (state_r == ecpad_pkg::ST_DONE) ovalid_r <= 1'b1;
    end
  end

  // datapath; operands reduced one after another through the divider
  logic [FB:0] rem_next;
  assign rem_next = div_ge ? div_trial - {1'b0, opx_r} : div_trial;

  always_ff @(posedge clk) begin
    cnt_r <= cnt_r + 1'b1;
    opy_r <= {opy_r[FB-2:0], 1'b0};
    case (state_r)
      ecpad_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          xp_r  <= in_data.px[FB-1:0];
          yp_r  <= in_data.py[FB-1:0];
          xq_r  <= in_data.qx[FB-1:0];
          yq_r  <= in_data.qy[FB-1:0];
          ca_r  <= a_r;
          sel_r <= 3'd0;
          cnt_r <= '0;
          rem_r <= '0;
          opx_r <= m_r;
          opy_r <= in_data.px[FB-1:0];
          deg_r <= m_r < ecpad_pkg::fe_t'(2);
          dbl_r <= in_data.px[FB-1:0] == in_data.qx[FB-1:0] &&
                   in_data.py[FB-1:0] == in_data.qy[FB-1:0];
          inf_r <= 1'b1;
        end
      end
      ecpad_pkg::ST_RED: begin
        rem_r <= rem_next[FB-1:0];
        if (div_last) begin
          case (sel_r)
            3'd0:    xp_r <= rem_next[FB-1:0];
            3'd1:    yp_r <= rem_next[FB-1:0];
            3'd2:    xq_r <= rem_next[FB-1:0];
            3'd3:    yq_r <= rem_next[FB-1:0];
            default: ca_r <= rem_next[FB-1:0];
          endcase
          sel_r <= sel_r + 3'd1;
          cnt_r <= '0;
          rem_r <= '0;
          case (sel_r)
            3'd0:    opy_r <= yp_r;
            3'd1:    opy_r <= xq_r;
            3'd2:    opy_r <= yq_r;
            default: opy_r <= ca_r;
          endcase
        end
      end
      ecpad_pkg::ST_PREP: begin
        dbl_r <= xp_r == xq_r && yp_r == yq_r;
        cnt_r <= '0;
        acc_r <= '0;
        opx_r <= xp_r;
        opy_r <= xp_r;
        num_r <= fsub(yq_r, yp_r, m_r);
        r0_r  <= m_r;
        r1_r  <= fsub(xq_r, xp_r, m_r);
        t0_r  <= '0;
        t1_r  <= ecpad_pkg::fe_t'(1);
        if (!(xp_r == xq_r && yp_r == yq_r)) begin
          opx_r <= fsub(xq_r, xp_r, m_r);
          opy_r <= m_r;
          rem_r <= '0;
        end
      end
      ecpad_pkg::ST_SQ: begin
        acc_r <= mul_step;
        if (done_cnt) sq_r <= mul_step;
      end
      ecpad_pkg::ST_NUM: begin
        num_r <= fadd(fadd(fadd(sq_r, sq_r, m_r), sq_r, m_r), ca_r, m_r);
        r1_r  <= fadd(yp_r, yp_r, m_r);
        opx_r <= fadd(yp_r, yp_r, m_r);
        opy_r <= m_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      ecpad_pkg::ST_INV_DIV: begin
        rem_r <= rem_next[FB-1:0];
        quo_r <= {quo_r[FB-2:0], div_ge};
        if (r1_r == '0) begin
          cnt_r <= '0;
          acc_r <= '0;
          opx_r <= num_r;
          opy_r <= t0_r;
        end else if (div_last) begin
          // quo < m always here except first round where r0=m; reduce via mul
          cnt_r <= '0;
          acc_r <= '0;
          opx_r <= t1_r;
          opy_r <= {quo_r[FB-2:0], div_ge};
        end
      end
      ecpad_pkg::ST_INV_MUL: acc_r <= mul_step;
      ecpad_pkg::ST_INV_UPD: begin
        r0_r  <= r1_r;
        r1_r  <= rem_r;
        t0_r  <= t1_r;
        t1_r  <= fsub(t0_r, acc_r, m_r);
        opx_r <= rem_r;
        opy_r <= r1_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      ecpad_pkg::ST_LAM: begin
        acc_r <= mul_step;
        if (done_cnt) begin
          lam_r <= mul_step;
          acc_r <= '0;
          opx_r <= mul_step;
          opy_r <= mul_step;
          cnt_r <= '0;
        end
      end
      ecpad_pkg::ST_LSQ: begin
        acc_r <= mul_step;
        if (done_cnt) x3_r <= fsub(fsub(mul_step, xp_r, m_r), xq_r, m_r);
      end
      ecpad_pkg::ST_X3: begin
        acc_r <= '0;
        opx_r <= lam_r;
        opy_r <= fsub(xp_r, x3_r, m_r);
        cnt_r <= '0;
      end
      ecpad_pkg::ST_Y3M: acc_r <= mul_step;
      ecpad_pkg::ST_Y3: begin
        inf_r <= 1'b0;
        out_r.ry <= 64'(fsub(acc_r, yp_r, m_r));
        out_r.rx <= 64'(x3_r);
      end
      ecpad_pkg::ST_DONE: begin
        out_r.at_infinity  <= inf_r;
        out_r.was_doubling <= dbl_r;
        if (inf_r) begin
          out_r.rx <= '0;
          out_r.ry <= '0;
        end
      end
      default: ;
    endcase
  end

  // quotient in the first round may equal m only when r1 is one; the
  // multiply step handles y >= m correctly since fadd keeps acc below m,
  // and opx=t1 is below m, so quo is used as-is.

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result waits");
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.at_infinity |-> out_data.rx == '0 && out_data.ry == '0)
    else $error("infinity with nonzero coordinates");

endmodule
